// ----- sv/tsqc_pkg.sv -----
// Package with constants, types and divider constants for the touch sample calibrator.
`default_nettype none

package tsqc_pkg;

    // Frame layout and field widths.
    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 13;
    localparam int COEF_W      = 16;
    localparam int WIN_W       = 8;
    localparam int SCREEN_W    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_DATA_W  = 64;

    // Position of the last byte of a frame.
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    // Calibration divisor and the width of the calibration numerator.
    localparam longint GAIN_SCALE = 10000;
    localparam longint RAW_MAX    = (64'sd1 <<< RAW_W) - 1;
    localparam longint COEF_MAG   = 64'sd1 <<< (COEF_W - 1);
    localparam longint NUM_MAX    = RAW_MAX * COEF_MAG + COEF_MAG * GAIN_SCALE;
    localparam int     NUM_W      = $clog2(NUM_MAX + 1);
    localparam int     NUM_SW     = NUM_W + 1;
    localparam int     GS_W       = $clog2(GAIN_SCALE + 1) + 1;

    localparam logic signed [GS_W-1:0] GAIN_SCALE_S = GS_W'(GAIN_SCALE);

    // Exact floor division by GAIN_SCALE for numerators below 2**NUM_W:
    // multiply by ceil(2**REC_SH / GAIN_SCALE) and keep the high bits.
    localparam int              SCALE_LOG = $clog2(GAIN_SCALE);
    localparam int              REC_SH    = NUM_W + SCALE_LOG;
    localparam longint unsigned REC_M     =
        ((64'd1 << REC_SH) + GAIN_SCALE - 1) / GAIN_SCALE;
    localparam logic [NUM_W:0]  REC_MUL   = REC_M[NUM_W:0];
    localparam int              PROD_W    = 2 * NUM_W + 1;
    localparam int              QUOT_W    = PROD_W - REC_SH;

    localparam logic [QUOT_W-1:0] SCREEN_MAX = QUOT_W'((64'd1 << SCREEN_W) - 1);

    // Register reset values.
    localparam logic signed [COEF_W-1:0] X_GAIN_RST   = 16'sd678;
    localparam logic signed [COEF_W-1:0] Y_GAIN_RST   = 16'sd920;
    localparam logic signed [COEF_W-1:0] X_OFFSET_RST = -16'sd19;
    localparam logic signed [COEF_W-1:0] Y_OFFSET_RST = -16'sd20;
    localparam logic [WIN_W-1:0]         WINDOW_RST   = 8'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_GAIN   = 3'd0,
        CFG_Y_GAIN   = 3'd1,
        CFG_X_OFFSET = 3'd2,
        CFG_Y_OFFSET = 3'd3,
        CFG_WINDOW   = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- sv/touch_sample_qualify_calibrate.sv -----
// Touch frame assembler, sample qualifier and calibrator, top level.
`default_nettype none

// Takes the reply bytes of a touch-converter frame one word per cycle on the
// s_ side; s_tuser high marks the first byte and restarts the frame. Without
// it the bytes keep filling successive positions and wrap after the eighth.
// The eighth byte produces one result word on the m_ side. The byte passes
// through five registers: a pairing stage, a qualify stage, a numerator
// multiply stage, a reciprocal multiply stage for the divide by 10000, and
// the output register. The block takes one byte every cycle; the pipeline
// stages only hold the stream when a finished result waits on m_tready and
// every stage behind it is full.
// Configuration writes are always taken and must be made while no frame result
// is in flight.
module touch_sample_qualify_calibrate
    import tsqc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  wire logic                   s_tuser,   // [0] frame_start

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // [12:0] raw_x, [25:13] raw_y,
                                                   // [41:26] screen_x, [57:42] screen_y
    output logic                        m_tuser,   // [0] sample_ok

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_data
);

    // Configuration registers.
    logic signed [COEF_W-1:0] x_gain_reg;
    logic signed [COEF_W-1:0] y_gain_reg;
    logic signed [COEF_W-1:0] x_offset_reg;
    logic signed [COEF_W-1:0] y_offset_reg;
    logic [WIN_W-1:0]         window_reg;

    // Frame assembly.
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_cur;
    logic [BYTE_W-1:0] frame_reg [FRAME_BYTES-1];
    logic              in_accept;
    logic              last_byte;

    // Stage 1: the four samples of a frame.
    logic             s1_valid_reg;
    logic [RAW_W-1:0] s1_y1_reg, s1_x1_reg, s1_y2_reg, s1_x2_reg;

    // Stage 2: qualified averages.
    logic             s2_valid_reg;
    logic             s2_ok_reg;
    logic [RAW_W-1:0] s2_raw_x_reg, s2_raw_y_reg;

    // Stage 3: calibration numerators.
    logic                     s3_valid_reg;
    logic                     s3_ok_reg;
    logic [RAW_W-1:0]         s3_raw_x_reg, s3_raw_y_reg;
    logic signed [NUM_SW-1:0] s3_num_x_reg, s3_num_y_reg;

    // Stage 4: reciprocal products.
    logic              s4_valid_reg;
    logic              s4_ok_reg;
    logic [RAW_W-1:0]  s4_raw_x_reg, s4_raw_y_reg;
    logic              s4_pos_x_reg, s4_pos_y_reg;
    logic [PROD_W-1:0] s4_prod_x_reg, s4_prod_y_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_ok_reg;

    // Stage advance chain: a stage loads when it is empty or drains.
    logic out_adv, s4_adv, s3_adv, s2_adv, s1_adv;

    assign out_adv = !m_valid_reg  || m_tready;
    assign s4_adv  = !s4_valid_reg || out_adv;
    assign s3_adv  = !s3_valid_reg || s4_adv;
    assign s2_adv  = !s2_valid_reg || s3_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;

    assign s_tready  = s1_adv;
    assign cfg_ready = 1'b1;

    assign in_accept = s_tvalid && s_tready;
    assign pos_cur   = s_tuser ? '0 : pos_reg;
    assign last_byte = (pos_cur == POS_LAST);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg   <= X_GAIN_RST;
            y_gain_reg   <= Y_GAIN_RST;
            x_offset_reg <= X_OFFSET_RST;
            y_offset_reg <= Y_OFFSET_RST;
            window_reg   <= WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_X_GAIN:   x_gain_reg   <= cfg_data;
                CFG_Y_GAIN:   y_gain_reg   <= cfg_data;
                CFG_X_OFFSET: x_offset_reg <= cfg_data;
                CFG_Y_OFFSET: y_offset_reg <= cfg_data;
                CFG_WINDOW:   window_reg   <= cfg_data[WIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Byte position within the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_accept)
        begin
            pos_reg <= last_byte ? '0 : pos_cur + 1'b1;
        end
    end

    // Frame byte store, one entry written per accepted word except a frame's last byte.
    always_ff @(posedge clk)
    begin
        if (in_accept && !last_byte)
        begin
            frame_reg[pos_cur] <= s_tdata;
        end
    end

    // Stage 1: pair the bytes into samples as (hi << 5) | (lo >> 3).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_accept && last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_accept && last_byte)
        begin
            s1_y1_reg <= {frame_reg[0], frame_reg[1][7:3]};
            s1_x1_reg <= {frame_reg[2], frame_reg[3][7:3]};
            s1_y2_reg <= {frame_reg[4], frame_reg[5][7:3]};
            s1_x2_reg <= {frame_reg[6], s_tdata[7:3]};
        end
    end

    // Stage 2: window check and floor averages.
    logic [RAW_W-1:0] diff_x, diff_y;
    logic [RAW_W:0]   sum_x, sum_y;
    logic             ok_next;

    always_comb
    begin
        diff_x  = (s1_x1_reg >= s1_x2_reg) ? s1_x1_reg - s1_x2_reg : s1_x2_reg - s1_x1_reg;
        diff_y  = (s1_y1_reg >= s1_y2_reg) ? s1_y1_reg - s1_y2_reg : s1_y2_reg - s1_y1_reg;
        sum_x   = {1'b0, s1_x1_reg} + {1'b0, s1_x2_reg};
        sum_y   = {1'b0, s1_y1_reg} + {1'b0, s1_y2_reg};
        ok_next = (diff_x < RAW_W'(window_reg)) && (diff_y < RAW_W'(window_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_ok_reg    <= ok_next;
            s2_raw_x_reg <= ok_next ? sum_x[RAW_W:1] : '0;
            s2_raw_y_reg <= ok_next ? sum_y[RAW_W:1] : '0;
        end
    end

    // Stage 3: numerator raw * gain + offset * GAIN_SCALE.
    logic signed [NUM_SW-1:0] num_x_next, num_y_next;

    always_comb
    begin
        num_x_next = NUM_SW'($signed({1'b0, s2_raw_x_reg}) * x_gain_reg)
                   + NUM_SW'(x_offset_reg * GAIN_SCALE_S);
        num_y_next = NUM_SW'($signed({1'b0, s2_raw_y_reg}) * y_gain_reg)
                   + NUM_SW'(y_offset_reg * GAIN_SCALE_S);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && s2_valid_reg)
        begin
            s3_ok_reg    <= s2_ok_reg;
            s3_raw_x_reg <= s2_raw_x_reg;
            s3_raw_y_reg <= s2_raw_y_reg;
            s3_num_x_reg <= num_x_next;
            s3_num_y_reg <= num_y_next;
        end
    end

    // Stage 4: divide by GAIN_SCALE as a multiply by its reciprocal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_adv && s3_valid_reg)
        begin
            s4_ok_reg     <= s3_ok_reg;
            s4_raw_x_reg  <= s3_raw_x_reg;
            s4_raw_y_reg  <= s3_raw_y_reg;
            s4_pos_x_reg  <= (s3_num_x_reg > 0);
            s4_pos_y_reg  <= (s3_num_y_reg > 0);
            s4_prod_x_reg <= PROD_W'(s3_num_x_reg[NUM_W-1:0]) * PROD_W'(REC_MUL);
            s4_prod_y_reg <= PROD_W'(s3_num_y_reg[NUM_W-1:0]) * PROD_W'(REC_MUL);
        end
    end

    // Output: quotient, clamp at zero for non-positive numerators, saturate.
    logic [QUOT_W-1:0]   quot_x, quot_y;
    logic [SCREEN_W-1:0] screen_x_next, screen_y_next;

    always_comb
    begin
        quot_x = s4_prod_x_reg[PROD_W-1:REC_SH];
        quot_y = s4_prod_y_reg[PROD_W-1:REC_SH];

        if (!s4_pos_x_reg)
            screen_x_next = '0;
        else if (quot_x > SCREEN_MAX)
            screen_x_next = '1;
        else
            screen_x_next = quot_x[SCREEN_W-1:0];

        if (!s4_pos_y_reg)
            screen_y_next = '0;
        else if (quot_y > SCREEN_MAX)
            screen_y_next = '1;
        else
            screen_y_next = quot_y[SCREEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s4_valid_reg)
        begin
            m_ok_reg   <= s4_ok_reg;
            m_data_reg <= {6'b0, screen_y_next, screen_x_next, s4_raw_y_reg, s4_raw_x_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

`ifndef ASSERT_OFF
    // The last byte of a frame always launches a sample into the pipeline.
    a_last_byte_launches: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte |=> s1_valid_reg)
        else $error("frame end did not launch a sample");

    // A rejected sample reports zero raw values.
    a_reject_zero_raw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[2*RAW_W-1:0] == '0))
        else $error("rejected sample carries raw data");

    // A new result only appears when stage 4 held an item.
    a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s4_valid_reg))
        else $error("result appeared without a stage 4 item");

    // A stalled sample in stage 1 keeps its samples.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |=> $stable(s1_x2_reg) && $stable(s1_y1_reg))
        else $error("stage 1 sample changed while stalled");
`endif

endmodule

`default_nettype wire
